// ===== hdl/cbf_pkg.sv =====
// Package for the comment blanking filter: character codes, scan mode type,
// queue word types and the single-byte scan function.
// No dependencies.
package cbf_pkg;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Output queue depth and its count width
    localparam int CBF_QDEPTH = 4;
    localparam int CBF_QCW    = $clog2(CBF_QDEPTH + 1);

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_STRING,
        MODE_BLOCK,
        MODE_LINE
    } t_mode;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_word;

    // Words produced by one accepted input byte, in stream order
    typedef struct packed {
        logic [1:0] cnt;
        t_word      w0;
        t_word      w1;
    } t_push;

    typedef struct packed {
        t_mode      mode;
        logic       pair;
        logic [7:0] o0;
    } t_scan;

    // Scan byte c with optional lookahead nx. A pair always emits two spaces.
    function automatic t_scan scan_one(t_mode mode, logic [7:0] prev, logic [7:0] c,
                                       logic has_next, logic [7:0] nx);
        t_scan r;
        t_mode m;
        r.mode = mode;
        r.pair = 1'b0;
        r.o0   = c;
        m      = mode;
        unique case (mode)
            MODE_NORMAL, MODE_STRING: begin
                if (c == CH_QUOTE && prev != CH_BSLASH) begin
                    m = (mode == MODE_NORMAL) ? MODE_STRING : MODE_NORMAL;
                end
                r.mode = m;
                if (m == MODE_NORMAL && c == CH_SLASH && has_next &&
                    (nx == CH_STAR || nx == CH_SLASH)) begin
                    r.mode = (nx == CH_STAR) ? MODE_BLOCK : MODE_LINE;
                    r.pair = 1'b1;
                    r.o0   = CH_SPACE;
                end
            end
            MODE_BLOCK: begin
                if (c == CH_STAR && has_next && nx == CH_SLASH) begin
                    r.mode = MODE_NORMAL;
                    r.pair = 1'b1;
                    r.o0   = CH_SPACE;
                end else begin
                    r.o0 = (c == CH_LF || c == CH_CR) ? c : CH_SPACE;
                end
            end
            MODE_LINE: begin
                if (c == CH_LF || c == CH_CR) begin
                    r.mode = MODE_NORMAL;
                end else begin
                    r.o0 = CH_SPACE;
                end
            end
            default: begin
                r.mode = MODE_NORMAL;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/cbf_scan.sv =====
// Scanner for the comment blanking filter: mode, lookahead byte and the
// previous output byte, updated once per accepted input word.
// Depends on cbf_pkg.
module cbf_scan (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_in_byte,
    input  logic           i_is_final,
    output cbf_pkg::t_push o_push
);
    import cbf_pkg::*;

    t_mode      r_mode, n_mode;
    logic [7:0] r_held, n_held;
    logic       r_held_valid, n_held_valid;
    logic [7:0] r_before, n_before;

    t_scan s_held, s_tail, s_lone;

    always_comb begin
        s_held = scan_one(r_mode, r_before, r_held, 1'b1, i_in_byte);
        s_tail = scan_one(s_held.mode, s_held.o0, i_in_byte, 1'b0, 8'h00);
        s_lone = scan_one(r_mode, r_before, i_in_byte, 1'b0, 8'h00);

        n_mode       = r_mode;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_before     = r_before;
        o_push       = '0;

        if (i_accept) begin
            if (r_held_valid) begin
                n_mode       = s_held.mode;
                n_held       = '0;
                n_held_valid = 1'b0;
                if (s_held.pair) begin
                    o_push.cnt = 2'd2;
                    o_push.w0  = '{data: CH_SPACE, fin: 1'b0};
                    o_push.w1  = '{data: CH_SPACE, fin: i_is_final};
                    n_before   = CH_SPACE;
                end else begin
                    o_push.w0 = '{data: s_held.o0, fin: 1'b0};
                    n_before  = s_held.o0;
                    if (i_is_final) begin
                        // flush the new byte too, without lookahead
                        o_push.cnt = 2'd2;
                        o_push.w1  = '{data: s_tail.o0, fin: 1'b1};
                    end else begin
                        o_push.cnt   = 2'd1;
                        n_held       = i_in_byte;
                        n_held_valid = 1'b1;
                    end
                end
            end else if (i_is_final) begin
                o_push.cnt = 2'd1;
                o_push.w0  = '{data: s_lone.o0, fin: 1'b1};
            end else begin
                n_held       = i_in_byte;
                n_held_valid = 1'b1;
            end

            // end of buffer: back to the reset state
            if (i_is_final) begin
                n_mode       = MODE_NORMAL;
                n_held       = '0;
                n_held_valid = 1'b0;
                n_before     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_NORMAL;
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_before     <= '0;
        end else begin
            r_mode       <= n_mode;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_before     <= n_before;
        end
    end

endmodule

// ===== hdl/cbf_outq.sv =====
// Output queue for the comment blanking filter: a shifting register queue
// that takes up to two words a cycle and presents its head on the port.
// Depends on cbf_pkg.
module cbf_outq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cbf_pkg::t_push              i_push,
    output logic [cbf_pkg::CBF_QCW-1:0] o_count,
    output logic                        o_valid,
    input  logic                        i_ready,
    output cbf_pkg::t_word              o_head
);
    import cbf_pkg::*;

    t_word              r_q [CBF_QDEPTH];
    t_word              n_q [CBF_QDEPTH];
    logic [CBF_QCW-1:0] r_cnt, n_cnt;
    logic               pop;
    logic [CBF_QCW-1:0] base;

    assign pop     = (r_cnt != '0) && i_ready;
    assign base    = r_cnt - CBF_QCW'(pop);
    assign o_count = r_cnt;
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_q[0];

    always_comb begin
        for (int i = 0; i < CBF_QDEPTH; i++) begin
            n_q[i] = r_q[i];
            // advance toward the head on a pop
            if (pop && i < CBF_QDEPTH - 1) begin
                n_q[i] = r_q[i+1];
            end
            if (i_push.cnt != 2'd0 && CBF_QCW'(i) == base) begin
                n_q[i] = i_push.w0;
            end
            if (i_push.cnt == 2'd2 && CBF_QCW'(i) == base + CBF_QCW'(1)) begin
                n_q[i] = i_push.w1;
            end
        end
        n_cnt = base + CBF_QCW'(i_push.cnt);
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== hdl/comment_blanking_filter.sv =====
// A byte's word is pushed into the output queue when the next byte is
//   accepted (one byte of lookahead); a final byte flushes when accepted.
// Throughput: one byte per cycle; ready stays low only while the four-word
//   output queue holds three or more words, which needs output stalls.
// Reset (synchronous, active low) clears the scan mode, the lookahead byte
//   and the output queue.
module comment_blanking_filter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_final,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_final
);
    import cbf_pkg::*;

    t_push              push;
    t_word              head;
    logic [CBF_QCW-1:0] q_count;
    logic               accept;

    // room for two words, the most one byte can produce
    assign o_ready = (q_count <= CBF_QCW'(CBF_QDEPTH - 2));
    assign accept  = i_valid && o_ready;

    cbf_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_in_byte  (i_in_byte),
        .i_is_final (i_is_final),
        .o_push     (push)
    );

    cbf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_count (q_count),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_head  (head)
    );

    assign o_out_byte  = head.data;
    assign o_out_final = head.fin;

endmodule

// ===== hdl/cbf_checker.sv =====
// Port-level checker for the comment blanking filter, bound to the top level.
// No dependencies.
module cbf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [7:0] i_in_byte,
    input logic       i_is_final,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_byte,
    input logic       o_out_final
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_out_byte) && $stable(o_out_final))
        else $error("output word changed while stalled");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_in_byte) && $stable(i_is_final))
        else $error("input word changed while waiting");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_final_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_is_final |=> o_valid)
        else $error("final byte did not flush a word");

endmodule

bind comment_blanking_filter cbf_checker u_cbf_checker (.*);

// ===== verif/comment_blanking_filter_tb.sv =====
// Testbench for comment_blanking_filter: drives text buffers through the byte channel,
// predicts the blanked output words and checks every word at the output channel.
// Depends on cbf_pkg (character codes, t_mode, t_word) and the filter RTL.
module comment_blanking_filter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cbf_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_BYTES = 750;

    // Predicts the filter output and holds the words still to come.
    class blanking_checker;
        t_mode      mode;
        logic [7:0] held;
        logic       held_ok;
        logic [7:0] prev_out;
        t_word      blanked_words_q[$];
        int         errors;
        int         words_checked;

        function new();
            restart();
            errors        = 0;
            words_checked = 0;
        endfunction

        function void restart();
            mode     = MODE_NORMAL;
            held     = 8'h00;
            held_ok  = 1'b0;
            prev_out = 8'h00;
        endfunction

        // Blank byte c given optional lookahead nx; returns 2 when nx joined c as a pair.
        function int blank_one(logic [7:0] c, logic has_nx, logic [7:0] nx,
                               output logic [7:0] w0, output logic [7:0] w1);
            w0 = c;
            w1 = CH_SPACE;
            case (mode)
                MODE_NORMAL, MODE_STRING: begin
                    if (c == CH_QUOTE && prev_out != CH_BSLASH) begin
                        mode = (mode == MODE_NORMAL) ? MODE_STRING : MODE_NORMAL;
                    end
                    if (mode == MODE_NORMAL && c == CH_SLASH && has_nx &&
                        (nx == CH_STAR || nx == CH_SLASH)) begin
                        mode = (nx == CH_STAR) ? MODE_BLOCK : MODE_LINE;
                        w0   = CH_SPACE;
                        return 2;
                    end
                    return 1;
                end
                MODE_BLOCK: begin
                    if (c == CH_STAR && has_nx && nx == CH_SLASH) begin
                        mode = MODE_NORMAL;
                        w0   = CH_SPACE;
                        return 2;
                    end
                    if (c != CH_LF && c != CH_CR) begin
                        w0 = CH_SPACE;
                    end
                    return 1;
                end
                default: begin
                    if (c == CH_LF || c == CH_CR) begin
                        mode = MODE_NORMAL;
                    end else begin
                        w0 = CH_SPACE;
                    end
                    return 1;
                end
            endcase
        endfunction

        function void take_byte(logic [7:0] b, logic fin);
            logic [7:0] outs [0:3];
            int         n;
            int         k;
            t_word      w;
            n = 0;
            if (held_ok) begin
                k       = blank_one(held, 1'b1, b, outs[0], outs[1]);
                held_ok = 1'b0;
                held    = 8'h00;
                n       = k;
                prev_out = outs[k-1];
                if (k == 1) begin
                    if (fin) begin
                        n += blank_one(b, 1'b0, 8'h00, outs[1], outs[2]);
                    end else begin
                        held    = b;
                        held_ok = 1'b1;
                    end
                end
            end else if (fin) begin
                n = blank_one(b, 1'b0, 8'h00, outs[0], outs[1]);
            end else begin
                held    = b;
                held_ok = 1'b1;
            end
            for (k = 0; k < n; k++) begin
                w.data = outs[k];
                w.fin  = fin && (k == n - 1);
                blanked_words_q.push_back(w);
            end
            // end of buffer: back to the reset state, open strings and comments included
            if (fin) begin
                restart();
            end
        endfunction

        function void match_word(logic [7:0] d, logic f, realtime t);
            t_word e;
            words_checked++;
            if (blanked_words_q.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected word, actual byte %h final %b", t, d, f);
                return;
            end
            e = blanked_words_q.pop_front();
            if (d !== e.data) begin
                errors++;
                $display("%0t ns: out_byte expected %h actual %h", t, e.data, d);
            end
            if (f !== e.fin) begin
                errors++;
                $display("%0t ns: out_final expected %b actual %b", t, e.fin, f);
            end
        endfunction

        function int pending();
            return blanked_words_q.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_in_byte   = 8'h00;
    logic       i_is_final  = 1'b0;
    logic       i_ready     = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_out_final;

    blanking_checker checker_h;
    int  bytes_sent   = 0;
    int  buffers_sent = 0;
    int  idle_cycles  = 0;
    bit  in_fast      = 1'b0;
    bit  out_fast     = 1'b0;

    comment_blanking_filter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_byte   (i_in_byte),
        .i_is_final  (i_is_final),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_out_final (o_out_final)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = in_fast ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_in_byte  <= b;
        i_is_final <= fin;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        checker_h.take_byte(b, fin);
        bytes_sent++;
        if (fin) begin
            buffers_sent++;
        end
    endtask

    task automatic send_text(input string s, input bit fin_last);
        int i;
        for (i = 0; i < s.len(); i++) begin
            send_byte(s[i], fin_last && (i == s.len() - 1));
        end
    endtask

    // Mostly delimiters, backslashes, line ends and spaces; some letters, some arbitrary bytes
    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 14) return CH_SLASH;
        if (r < 26) return CH_STAR;
        if (r < 36) return CH_QUOTE;
        if (r < 44) return CH_BSLASH;
        if (r < 50) return CH_LF;
        if (r < 54) return CH_CR;
        if (r < 60) return CH_SPACE;
        if (r < 85) return 8'(8'h61 + $urandom_range(0, 25));
        return 8'($urandom_range(0, 255));
    endfunction

    // Append one token: plain text, block comment, line comment, string or noise.
    task automatic add_token(ref logic [7:0] buf_q[$]);
        int n;
        int i;
        n = $urandom_range(0, 4);
        case ($urandom_range(0, 5))
            0: begin
                for (i = 0; i <= n; i++) buf_q.push_back(8'(8'h61 + $urandom_range(0, 25)));
            end
            1: begin
                buf_q.push_back(CH_SLASH);
                buf_q.push_back(CH_STAR);
                for (i = 0; i < n; i++) buf_q.push_back(pick_text_byte());
                if ($urandom_range(0, 7) != 0) begin
                    buf_q.push_back(CH_STAR);
                    buf_q.push_back(CH_SLASH);
                end
            end
            2: begin
                buf_q.push_back(CH_SLASH);
                buf_q.push_back(CH_SLASH);
                for (i = 0; i < n; i++) buf_q.push_back(pick_text_byte());
                buf_q.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
            end
            3: begin
                buf_q.push_back(CH_QUOTE);
                for (i = 0; i < n; i++) begin
                    if ($urandom_range(0, 3) == 0) buf_q.push_back(CH_BSLASH);
                    buf_q.push_back(pick_text_byte());
                end
                buf_q.push_back(CH_QUOTE);
            end
            default: begin
                for (i = 0; i <= n; i++) buf_q.push_back(pick_text_byte());
            end
        endcase
    endtask

    task automatic send_random_buffer();
        logic [7:0] buf_q[$];
        int         tokens;
        int         i;
        if ($urandom_range(0, 9) == 0) begin
            buf_q.push_back(8'($urandom_range(0, 255)));
        end else if ($urandom_range(0, 4) == 0) begin
            // noise buffer
            tokens = $urandom_range(1, 12);
            for (i = 0; i < tokens; i++) buf_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            tokens = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 15) : $urandom_range(1, 5);
            for (i = 0; i < tokens; i++) add_token(buf_q);
        end
        for (i = 0; i < buf_q.size(); i++) begin
            send_byte(buf_q[i], i == buf_q.size() - 1);
        end
    endtask

    // Output side: unless in fast mode, stall for a random time before each word
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = out_fast ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            checker_h.match_word(o_out_byte, o_out_final, $realtime);
            if ($urandom_range(0, 31) == 0) begin
                out_fast = ~out_fast;
            end
        end
    end

    // End the run when no word moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        checker_h = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // final slash alone: no lookahead, no comment
        send_text("/", 1'b1);
        // block comment keeps CR, star on the final byte
        send_text("/*\015*", 1'b1);
        // escaped quote inside a string, then a line comment ended by CR
        send_text("\"\\\"/*\"//", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(8'h00, 1'b1);
        // quote after a doubled backslash stays in the string
        send_text("\"\\\\\"/", 1'b1);
        // quote right after a comment that held a backslash
        send_text("/*\\*/\"", 1'b1);

        while (bytes_sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 3) == 0) begin
                in_fast = ~in_fast;
            end
            send_random_buffer();
        end
        i_valid <= 1'b0;

        while (checker_h.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("Sent %0d bytes in %0d buffers, checked %0d output words.",
                 bytes_sent, buffers_sent, checker_h.words_checked);
        if (checker_h.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
